// File: rtl/core/rgbc_pkg.sv
// ----------------------------------------------------------------------------
// rgbc_pkg
// Shared types and constants of the RGB 3x3 convolution block.
// ----------------------------------------------------------------------------
package rgbc_pkg;

    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int MAX_HEIGHT_DEF  = 1024;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam int PIX_W     = 8;
    localparam int CH_NUM    = 3;
    localparam int RGB_W     = PIX_W * CH_NUM;
    localparam int SIZE_W    = 11;
    localparam int WREG_W    = 48;
    localparam int FIELD_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int PIX_MAX   = 255;
    localparam int KERNEL_N  = 3;

    localparam logic [SIZE_W-1:0] SIZE_RESET    = SIZE_W'(1024);
    localparam logic [WREG_W-1:0] WEIGHT_RESET  = WREG_W'(0);
    localparam logic [WREG_W-1:0] WMID_RESET    = WREG_W'(268435456);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_WEIGHTS_TOP  = 3'd2,
        REG_WEIGHTS_MID  = 3'd3,
        REG_WEIGHTS_BOT  = 3'd4
    } cfg_index_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } opcode_t;

    typedef logic [RGB_W-1:0] rgb_t;

    // [row][column], column 2 is the newest
    typedef logic [KERNEL_N-1:0][KERNEL_N-1:0][RGB_W-1:0] window_t;

    typedef struct packed {
        logic wr;
        logic bot_zero;
        logic produce;
        logic mask_top;
        logic mask_bot;
        logic mask_left;
        logic mask_right;
        logic eof;
    } step_ctrl_t;

endpackage

// File: rtl/core/rgbc_if.sv
// ----------------------------------------------------------------------------
// rgbc_pixel_if / rgbc_result_if
// Valid/ready channels for incoming pixel words and outgoing result words.
// ----------------------------------------------------------------------------
interface rgbc_pixel_if;
    import rgbc_pkg::*;

    logic              valid;
    logic              ready;
    logic              opcode;
    logic [PIX_W-1:0]  pixel_red;
    logic [PIX_W-1:0]  pixel_green;
    logic [PIX_W-1:0]  pixel_blue;

    modport source (output valid, opcode, pixel_red, pixel_green, pixel_blue,
                    input ready);
    modport sink   (input valid, opcode, pixel_red, pixel_green, pixel_blue,
                    output ready);
endinterface

interface rgbc_result_if;
    import rgbc_pkg::*;

    logic              valid;
    logic              ready;
    logic [PIX_W-1:0]  out_red;
    logic [PIX_W-1:0]  out_green;
    logic [PIX_W-1:0]  out_blue;
    logic              end_of_frame;

    modport source (output valid, out_red, out_green, out_blue, end_of_frame,
                    input ready);
    modport sink   (input valid, out_red, out_green, out_blue, end_of_frame,
                    output ready);
endinterface

// File: rtl/core/rgbc_ctrl.sv
// ----------------------------------------------------------------------------
// rgbc_ctrl
// Frame counters, size registers and per-word step decode.
// ----------------------------------------------------------------------------
module rgbc_ctrl #(
    parameter int MAX_WIDTH  = rgbc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rgbc_pkg::MAX_HEIGHT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [rgbc_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [rgbc_pkg::SIZE_W-1:0]      wr_size,
    input  logic                             take,
    input  logic                             opcode,
    output logic                             drop,
    output logic [$clog2(MAX_WIDTH)-1:0]     addr,
    output rgbc_pkg::step_ctrl_t             ctrl
);
    import rgbc_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int XW = AW + 1;
    localparam int HX = RW + 1;
    localparam int FW = $clog2(MAX_WIDTH + 2);

    logic [SIZE_W-1:0] width_reg, width_next;
    logic [SIZE_W-1:0] height_reg, height_next;
    logic [AW-1:0]     in_col_reg, in_col_next;
    logic [RW-1:0]     in_row_reg, in_row_next;
    logic [AW-1:0]     out_col_reg, out_col_next;
    logic [RW-1:0]     out_row_reg, out_row_next;
    logic              done_reg, done_next;
    logic [FW-1:0]     fill_reg, fill_next;

    logic [XW-1:0]     w_eff;
    logic [HX-1:0]     h_eff;
    logic [AW-1:0]     col;
    logic              col_last;
    logic              in_row_last;
    logic              out_col_last;
    logic              out_row_last;
    logic              produce;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = XW'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = XW'(MAX_WIDTH);
        else
            w_eff = XW'(width_reg);

        if (height_reg == '0)
            h_eff = HX'(1);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = HX'(MAX_HEIGHT);
        else
            h_eff = HX'(height_reg);

        col          = (XW'(in_col_reg) < w_eff) ? in_col_reg : '0;
        col_last     = (XW'(col) + XW'(1)) >= w_eff;
        in_row_last  = (HX'(in_row_reg) + HX'(1)) >= h_eff;
        out_col_last = (XW'(out_col_reg) + XW'(1)) >= w_eff;
        out_row_last = (HX'(out_row_reg) + HX'(1)) >= h_eff;
        produce      = fill_reg > FW'(w_eff);

        drop = ((opcode == OP_FLUSH) && !done_reg) || (done_reg && (fill_reg == '0));
        addr = col;

        ctrl.wr         = !done_reg;
        ctrl.bot_zero   = done_reg;
        ctrl.produce    = produce;
        ctrl.mask_top   = (out_row_reg == '0);
        ctrl.mask_bot   = out_row_last;
        ctrl.mask_left  = (out_col_reg == '0);
        ctrl.mask_right = out_col_last;
        ctrl.eof        = out_row_last && out_col_last;
    end

    always_comb
    begin
        width_next   = width_reg;
        height_next  = height_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        done_next    = done_reg;
        fill_next    = fill_reg;

        if (wr_en)
        begin
            case (wr_index)
                REG_IMAGE_WIDTH,
                REG_IMAGE_HEIGHT:
                begin
                    if (wr_index == REG_IMAGE_WIDTH)
                        width_next = wr_size;
                    else
                        height_next = wr_size;
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                    done_next    = 1'b0;
                    fill_next    = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (take && !drop)
        begin
            if (col_last)
            begin
                in_col_next = '0;
                if (!done_reg)
                begin
                    if (in_row_last)
                    begin
                        done_next   = 1'b1;
                        in_row_next = '0;
                    end
                    else
                    begin
                        in_row_next = in_row_reg + RW'(1);
                    end
                end
            end
            else
            begin
                in_col_next = col + AW'(1);
            end

            if (!produce)
            begin
                fill_next = fill_reg + FW'(1);
            end
            else if (out_row_last && out_col_last)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
                fill_next    = '0;
            end
            else if (out_col_last)
            begin
                out_col_next = '0;
                out_row_next = out_row_reg + RW'(1);
            end
            else
            begin
                out_col_next = out_col_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= SIZE_RESET;
            height_reg  <= SIZE_RESET;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            done_reg    <= 1'b0;
            fill_reg    <= '0;
        end
        else
        begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            done_reg    <= done_next;
            fill_reg    <= fill_next;
        end
    end

endmodule

// File: rtl/core/rgbc_line.sv
// ----------------------------------------------------------------------------
// rgbc_line
// Two line memories with read-modify-write forwarding and the 3x3 window.
// ----------------------------------------------------------------------------
module rgbc_line #(
    parameter int MAX_WIDTH = rgbc_pkg::MAX_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          step,
    input  logic [$clog2(MAX_WIDTH)-1:0]  addr,
    input  rgbc_pkg::step_ctrl_t          ctrl,
    input  rgbc_pkg::rgb_t                px,
    output rgbc_pkg::window_t             win,
    output logic                          win_valid,
    output rgbc_pkg::step_ctrl_t          win_ctrl
);
    import rgbc_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    rgb_t        upper_mem [MAX_WIDTH];
    rgb_t        middle_mem [MAX_WIDTH];

    logic        s1_valid_reg;
    step_ctrl_t  s1_ctrl_reg;
    logic [AW-1:0] s1_addr_reg;
    rgb_t        s1_px_reg;
    rgb_t        rd_up_reg;
    rgb_t        rd_mid_reg;

    logic        lw_valid_reg;
    logic [AW-1:0] lw_addr_reg;
    rgb_t        lw_up_reg;
    rgb_t        lw_mid_reg;

    window_t     win_reg;
    logic        win_valid_reg;
    step_ctrl_t  win_ctrl_reg;

    logic        hit;
    rgb_t        top_eff;
    rgb_t        mid_eff;
    logic        wr_now;

    always_comb
    begin
        hit     = lw_valid_reg && (lw_addr_reg == s1_addr_reg);
        top_eff = hit ? lw_up_reg  : rd_up_reg;
        mid_eff = hit ? lw_mid_reg : rd_mid_reg;
        wr_now  = adv && s1_valid_reg && s1_ctrl_reg.wr;
    end

    always_ff @(posedge clk)
    begin
        if (adv && step)
        begin
            rd_up_reg  <= upper_mem[addr];
            rd_mid_reg <= middle_mem[addr];
        end
        if (wr_now)
        begin
            upper_mem[s1_addr_reg]  <= mid_eff;
            middle_mem[s1_addr_reg] <= s1_px_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && step)
        begin
            s1_ctrl_reg <= ctrl;
            s1_addr_reg <= addr;
            s1_px_reg   <= px;
        end
        if (wr_now)
        begin
            lw_addr_reg <= s1_addr_reg;
            lw_up_reg   <= mid_eff;
            lw_mid_reg  <= s1_px_reg;
        end
        if (adv && s1_valid_reg)
            win_ctrl_reg <= s1_ctrl_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            lw_valid_reg  <= 1'b0;
            win_valid_reg <= 1'b0;
            win_reg       <= '0;
        end
        else
        begin
            if (wr_now)
                lw_valid_reg <= 1'b1;
            if (adv)
            begin
                s1_valid_reg  <= step;
                win_valid_reg <= s1_valid_reg && s1_ctrl_reg.produce;
                if (s1_valid_reg)
                begin
                    for (int r = 0; r < KERNEL_N; r++)
                    begin
                        win_reg[r][0] <= win_reg[r][1];
                        win_reg[r][1] <= win_reg[r][2];
                    end
                    win_reg[0][2] <= top_eff;
                    win_reg[1][2] <= mid_eff;
                    win_reg[2][2] <= s1_ctrl_reg.bot_zero ? '0 : s1_px_reg;
                end
            end
        end
    end

    assign win       = win_reg;
    assign win_valid = win_valid_reg;
    assign win_ctrl  = win_ctrl_reg;

endmodule

// File: rtl/core/rgbc_mac.sv
// ----------------------------------------------------------------------------
// rgbc_mac
// Weighted sum of the window per channel, clamp, and the output register.
// ----------------------------------------------------------------------------
module rgbc_mac #(
    parameter int WEIGHT_BITS = rgbc_pkg::WEIGHT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [rgbc_pkg::WREG_W-1:0]   w_top,
    input  logic [rgbc_pkg::WREG_W-1:0]   w_mid,
    input  logic [rgbc_pkg::WREG_W-1:0]   w_bot,
    input  rgbc_pkg::window_t             win,
    input  logic                          win_valid,
    input  rgbc_pkg::step_ctrl_t          win_ctrl,
    input  logic                          out_ready,
    output logic                          adv,
    output logic                          out_valid,
    output logic [rgbc_pkg::PIX_W-1:0]    out_red,
    output logic [rgbc_pkg::PIX_W-1:0]    out_green,
    output logic [rgbc_pkg::PIX_W-1:0]    out_blue,
    output logic                          out_eof
);
    import rgbc_pkg::*;

    localparam int FRAC = WEIGHT_BITS - 4;
    localparam int PW   = WEIGHT_BITS + PIX_W + 1;
    localparam int RSW  = PW + 2;
    localparam int TW   = PW + 4;

    logic [KERNEL_N-1:0][WREG_W-1:0] wrow;
    logic [KERNEL_N-1:0][KERNEL_N-1:0] mask;

    logic signed [PW-1:0]  prod_reg [KERNEL_N][KERNEL_N][CH_NUM];
    logic signed [RSW-1:0] row_reg  [KERNEL_N][CH_NUM];
    logic signed [TW-1:0]  tot_reg  [CH_NUM];
    logic                  a_valid_reg, b_valid_reg, c_valid_reg;
    logic                  a_eof_reg, b_eof_reg, c_eof_reg;

    logic                  out_valid_reg;
    logic [CH_NUM-1:0][PIX_W-1:0] out_reg;
    logic                  out_eof_reg;
    logic [CH_NUM-1:0][PIX_W-1:0] clamp_next;

    assign adv = !out_valid_reg || out_ready;

    always_comb
    begin
        wrow[0] = w_top;
        wrow[1] = w_mid;
        wrow[2] = w_bot;
        for (int r = 0; r < KERNEL_N; r++)
        begin
            for (int c = 0; c < KERNEL_N; c++)
            begin
                mask[r][c] = (r == 0 && win_ctrl.mask_top) ||
                             (r == KERNEL_N - 1 && win_ctrl.mask_bot) ||
                             (c == 0 && win_ctrl.mask_left) ||
                             (c == KERNEL_N - 1 && win_ctrl.mask_right);
            end
        end
    end

    always_comb
    begin
        logic signed [TW-1:0] q;
        for (int ch = 0; ch < CH_NUM; ch++)
        begin
            q = tot_reg[ch] >>> FRAC;
            if (tot_reg[ch] < 0)
                clamp_next[ch] = '0;
            else if (q > TW'(PIX_MAX))
                clamp_next[ch] = PIX_W'(PIX_MAX);
            else
                clamp_next[ch] = q[PIX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < KERNEL_N; r++)
            begin
                for (int c = 0; c < KERNEL_N; c++)
                begin
                    for (int ch = 0; ch < CH_NUM; ch++)
                    begin
                        if (mask[r][c])
                            prod_reg[r][c][ch] <= '0;
                        else
                            prod_reg[r][c][ch] <=
                                PW'($signed({1'b0, win[r][c][PIX_W*ch +: PIX_W]})) *
                                PW'($signed(wrow[r][FIELD_W*c +: WEIGHT_BITS]));
                    end
                end
            end
            for (int r = 0; r < KERNEL_N; r++)
            begin
                for (int ch = 0; ch < CH_NUM; ch++)
                begin
                    row_reg[r][ch] <= RSW'(prod_reg[r][0][ch]) + RSW'(prod_reg[r][1][ch]) +
                                      RSW'(prod_reg[r][2][ch]);
                end
            end
            for (int ch = 0; ch < CH_NUM; ch++)
            begin
                tot_reg[ch] <= TW'(row_reg[0][ch]) + TW'(row_reg[1][ch]) +
                               TW'(row_reg[2][ch]);
            end
            a_eof_reg   <= win_ctrl.eof;
            b_eof_reg   <= a_eof_reg;
            c_eof_reg   <= b_eof_reg;
            out_reg     <= clamp_next;
            out_eof_reg <= c_eof_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= win_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            out_valid_reg <= c_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = out_reg[0];
    assign out_green = out_reg[1];
    assign out_blue  = out_reg[2];
    assign out_eof   = out_eof_reg;

endmodule

// File: rtl/core/rgb_convolution_3x3.sv
// ----------------------------------------------------------------------------
// rgb_convolution_3x3
// Streaming zero-padded 3x3 convolution of an RGB frame in raster order.
// ----------------------------------------------------------------------------
// One word is taken every clock while the result side keeps up; the pipeline
// stalls as a whole only when a result waits untaken. Each word does one
// read-modify-write of the two line memories (one read port, one write port
// each, read data registered); a write to the entry that the next word reads
// is forwarded. The result for a pixel is computed by the word that comes
// width+1 words later and passes through the read, window, product, row-sum,
// total and output registers. The line memories have no clearing pass: rows
// outside the image are masked and never-written entries are never used.
// After the last pixel, width+1 flush words drain the frame; writing the
// width or height restarts the frame.
module rgb_convolution_3x3 #(
    parameter int MAX_WIDTH   = rgbc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = rgbc_pkg::MAX_HEIGHT_DEF,
    parameter int WEIGHT_BITS = rgbc_pkg::WEIGHT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [rgbc_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [rgbc_pkg::WREG_W-1:0]     wr_data,
    rgbc_pixel_if.sink                      pixel,
    rgbc_result_if.source                   result
);
    import rgbc_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic [WREG_W-1:0] w_top_reg, w_mid_reg, w_bot_reg;
    logic              adv;
    logic              take;
    logic              drop;
    logic [AW-1:0]     addr;
    step_ctrl_t        ctrl;
    window_t           win;
    logic              win_valid;
    step_ctrl_t        win_ctrl;

    assign pixel.ready = adv;
    assign take        = pixel.valid && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_top_reg <= WEIGHT_RESET;
            w_mid_reg <= WMID_RESET;
            w_bot_reg <= WEIGHT_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_WEIGHTS_TOP: w_top_reg <= wr_data;
                REG_WEIGHTS_MID: w_mid_reg <= wr_data;
                REG_WEIGHTS_BOT: w_bot_reg <= wr_data;
                default:
                begin
                end
            endcase
        end
    end

    rgbc_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_size  (wr_data[SIZE_W-1:0]),
        .take     (take),
        .opcode   (pixel.opcode),
        .drop     (drop),
        .addr     (addr),
        .ctrl     (ctrl)
    );

    rgbc_line #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .step      (take && !drop),
        .addr      (addr),
        .ctrl      (ctrl),
        .px        ({pixel.pixel_blue, pixel.pixel_green, pixel.pixel_red}),
        .win       (win),
        .win_valid (win_valid),
        .win_ctrl  (win_ctrl)
    );

    rgbc_mac #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .w_top     (w_top_reg),
        .w_mid     (w_mid_reg),
        .w_bot     (w_bot_reg),
        .win       (win),
        .win_valid (win_valid),
        .win_ctrl  (win_ctrl),
        .out_ready (result.ready),
        .adv       (adv),
        .out_valid (result.valid),
        .out_red   (result.out_red),
        .out_green (result.out_green),
        .out_blue  (result.out_blue),
        .out_eof   (result.end_of_frame)
    );

endmodule

// File: rtl/core/rgbc_checker.sv
// ----------------------------------------------------------------------------
// rgbc_checker
// Port-level checks of the RGB 3x3 convolution block.
// ----------------------------------------------------------------------------
module rgbc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [rgbc_pkg::PIX_W-1:0]    out_red,
    input logic [rgbc_pkg::PIX_W-1:0]    out_green,
    input logic [rgbc_pkg::PIX_W-1:0]    out_blue,
    input logic                          end_of_frame
);
    import rgbc_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_red) &&
        $stable(out_green) && $stable(out_blue) && $stable(end_of_frame))
        else $error("result word changed while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_ready_when_taken: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> in_ready)
        else $error("input stalled while result taken");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid out of reset");

endmodule

bind rgb_convolution_3x3 rgbc_checker u_rgbc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (pixel.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_red      (result.out_red),
    .out_green    (result.out_green),
    .out_blue     (result.out_blue),
    .end_of_frame (result.end_of_frame)
);

// File: verif/rgb_convolution_3x3_tb.sv
// ----------------------------------------------------------------------------
// rgb_convolution_3x3_tb
// Streams RGB frames through the 3x3 convolution block under several sizes,
// weight sets and idle/stall patterns. A local line-store model predicts each
// filtered word, and a checker compares every accepted result with it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rgb_convolution_3x3_tb;
    import rgbc_pkg::*;

    localparam int MAXW      = MAX_WIDTH_DEF;
    localparam int MAXH      = MAX_HEIGHT_DEF;
    localparam int FRAC      = WEIGHT_BITS_DEF - 4;
    localparam int SETTLE    = 20;
    localparam int STALL_MAX = 5000;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             eof;
    } filt_word_t;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [WREG_W-1:0] wr_data;

    rgbc_pixel_if  pix_if ();
    rgbc_result_if res_if ();

    rgb_convolution_3x3 dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .pixel    (pix_if),
        .result   (res_if)
    );

    // filter model state
    logic [SIZE_W-1:0] cfg_width;
    logic [SIZE_W-1:0] cfg_height;
    logic [WREG_W-1:0] cfg_weights [3];
    rgb_t upper_row [MAXW];
    rgb_t middle_row [MAXW];
    rgb_t win [9];
    int unsigned in_col, in_row, out_col, out_row, fill_cnt;
    bit frame_in_done;

    filt_word_t expected_pixels [$];
    int errors;
    int idle_pct;
    int stall_pct;
    int quiet_cycles;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic int unsigned used_size(logic [SIZE_W-1:0] v, int unsigned lim);
        if (v == 0)
            return 1;
        return (v > lim) ? lim : v;
    endfunction

    function automatic logic [PIX_W-1:0] clamp_channel(longint acc);
        longint q;
        if (acc < 0)
            return '0;
        q = acc >>> FRAC;
        return (q > PIX_MAX) ? PIX_W'(PIX_MAX) : PIX_W'(q);
    endfunction

    function automatic void restart_frame();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        frame_in_done = 0;
        fill_cnt = 0;
    endfunction

    function automatic void filter_word(opcode_t op, rgb_t px);
        int unsigned w, h, col;
        rgb_t top, mid, bot, p;
        longint acc [3];
        logic signed [FIELD_W-1:0] wf;
        filt_word_t e;
        w = used_size(cfg_width, MAXW);
        h = used_size(cfg_height, MAXH);
        if (op == OP_FLUSH && !frame_in_done)
            return;
        if (frame_in_done && fill_cnt == 0)
            return;
        col = (in_col < w) ? in_col : 0;
        top = upper_row[col];
        mid = middle_row[col];
        bot = frame_in_done ? '0 : px;
        if (!frame_in_done)
        begin
            upper_row[col] = mid;
            middle_row[col] = px;
        end
        for (int r = 0; r < 3; r++)
        begin
            win[r*3] = win[r*3+1];
            win[r*3+1] = win[r*3+2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = bot;
        col++;
        if (col >= w)
        begin
            col = 0;
            if (!frame_in_done)
            begin
                if (in_row + 1 >= h)
                begin
                    frame_in_done = 1;
                    in_row = 0;
                end
                else
                    in_row++;
            end
        end
        in_col = col;
        if (fill_cnt < w + 1)
        begin
            fill_cnt++;
            return;
        end
        acc = '{0, 0, 0};
        for (int r = 0; r < 3; r++)
        begin
            if (r == 0 && out_row == 0)
                continue;
            if (r == 2 && out_row + 1 >= h)
                continue;
            for (int c = 0; c < 3; c++)
            begin
                if (c == 0 && out_col == 0)
                    continue;
                if (c == 2 && out_col + 1 >= w)
                    continue;
                wf = cfg_weights[r][FIELD_W*c +: FIELD_W];
                p = win[r*3+c];
                for (int k = 0; k < 3; k++)
                    acc[k] += longint'(p[PIX_W*k +: PIX_W]) * longint'(wf);
            end
        end
        e.red = clamp_channel(acc[0]);
        e.green = clamp_channel(acc[1]);
        e.blue = clamp_channel(acc[2]);
        e.eof = (out_row + 1 >= h) && (out_col + 1 >= w);
        expected_pixels.push_back(e);
        if (e.eof)
        begin
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
            fill_cnt = 0;
        end
        else if (out_col + 1 >= w)
        begin
            out_col = 0;
            out_row++;
        end
        else
            out_col++;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        errors++;
    endtask

    // result sink: random stall, check at mid-cycle
    always @(posedge clk)
        res_if.ready <= ($urandom_range(99) >= stall_pct);

    always @(negedge clk)
    begin
        filt_word_t e;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch("result word with nothing expected");
            else
            begin
                e = expected_pixels.pop_front();
                if (res_if.out_red !== e.red)
                    report_mismatch($sformatf("red %0d, want %0d", res_if.out_red, e.red));
                if (res_if.out_green !== e.green)
                    report_mismatch($sformatf("green %0d, want %0d",
                                              res_if.out_green, e.green));
                if (res_if.out_blue !== e.blue)
                    report_mismatch($sformatf("blue %0d, want %0d", res_if.out_blue, e.blue));
                if (res_if.end_of_frame !== e.eof)
                    report_mismatch($sformatf("end_of_frame %0b, want %0b",
                                              res_if.end_of_frame, e.eof));
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX)
        begin
            $display("rgb_convolution_3x3 test failed");
            $finish;
        end
    end

    task automatic set_phase(int k);
        case (k % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 65; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 65; end
            default: begin idle_pct = 20; stall_pct = 20; end
        endcase
    endtask

    task automatic send_word(opcode_t op, rgb_t px);
        bit got;
        while ($urandom_range(99) < idle_pct)
        begin
            pix_if.valid <= 1'b0;
            @(posedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.opcode <= op;
        pix_if.pixel_red <= px[7:0];
        pix_if.pixel_green <= px[15:8];
        pix_if.pixel_blue <= px[23:16];
        do
        begin
            @(negedge clk);
            got = pix_if.ready;
            @(posedge clk);
        end
        while (!got);
        filter_word(op, px);
    endtask

    task automatic wait_idle();
        pix_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [WREG_W-1:0] val);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:  begin cfg_width = val[SIZE_W-1:0]; restart_frame(); end
            REG_IMAGE_HEIGHT: begin cfg_height = val[SIZE_W-1:0]; restart_frame(); end
            REG_WEIGHTS_TOP:  cfg_weights[0] = val;
            REG_WEIGHTS_MID:  cfg_weights[1] = val;
            default:          cfg_weights[2] = val;
        endcase
    endtask

    task automatic set_weights(logic [WREG_W-1:0] t, logic [WREG_W-1:0] m,
                               logic [WREG_W-1:0] b);
        write_reg(REG_WEIGHTS_TOP, t);
        write_reg(REG_WEIGHTS_MID, m);
        write_reg(REG_WEIGHTS_BOT, b);
    endtask

    function automatic rgb_t rand_pixel();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            default: return RGB_W'($urandom);
        endcase
    endfunction

    function automatic logic [WREG_W-1:0] rand_weights();
        logic [WREG_W-1:0] v;
        v = WREG_W'({$urandom, $urandom});
        for (int c = 0; c < 3; c++)
            case ($urandom_range(5))
                0: v[FIELD_W*c +: FIELD_W] = 16'h8000;
                1: v[FIELD_W*c +: FIELD_W] = 16'h7FFF;
                2: v[FIELD_W*c +: FIELD_W] = 16'(($urandom_range(8192)) - 4096);
                3: v[FIELD_W*c +: FIELD_W] = 16'h0000;
                default: ;
            endcase
        return v;
    endfunction

    task automatic stream_frame(int unsigned w, int unsigned h, int noise_pct);
        for (int i = 0; i < w * h; i++)
        begin
            if ($urandom_range(99) < noise_pct)
                send_word(OP_FLUSH, rand_pixel());
            send_word(OP_PIXEL, rand_pixel());
        end
        for (int i = 0; i <= w; i++)
            send_word(($urandom_range(99) < noise_pct) ? OP_PIXEL : OP_FLUSH, rand_pixel());
    endtask

    task automatic test_directed();
        set_phase(0);
        write_reg(REG_IMAGE_WIDTH, WREG_W'(3));
        write_reg(REG_IMAGE_HEIGHT, WREG_W'(2));
        set_weights({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
        send_word(OP_FLUSH, '1);
        for (int i = 0; i < 6; i++)
            send_word(OP_PIXEL, (i % 2) ? '1 : '0);
        send_word(OP_PIXEL, '1);
        for (int i = 0; i < 3; i++)
            send_word(OP_FLUSH, '0);
        send_word(OP_FLUSH, '1);
        send_word(OP_PIXEL, '1);
        wait_idle();
        set_weights({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
        write_reg(REG_IMAGE_WIDTH, WREG_W'(0));
        write_reg(REG_IMAGE_HEIGHT, WREG_W'(0));
        send_word(OP_PIXEL, '1);
        send_word(OP_FLUSH, '1);
        send_word(OP_FLUSH, '1);
        wait_idle();
    endtask

    task automatic test_size_extremes();
        set_phase(0);
        set_weights(rand_weights(), rand_weights(), rand_weights());
        write_reg(REG_IMAGE_WIDTH, WREG_W'(11'h7FF));
        write_reg(REG_IMAGE_HEIGHT, WREG_W'(1));
        for (int i = 0; i < 200; i++)
            send_word(OP_PIXEL, rand_pixel());
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, WREG_W'(1));
        write_reg(REG_IMAGE_HEIGHT, WREG_W'(11'h7FF));
        for (int i = 0; i < 200; i++)
            send_word(OP_PIXEL, rand_pixel());
        wait_idle();
    endtask

    task automatic test_random_frames();
        int sent;
        int frame;
        int n;
        int unsigned w, h;
        sent = 0;
        frame = 0;
        while (sent < 630)
        begin
            set_phase(frame);
            if ($urandom_range(3) == 0)
                set_weights({16'h0000, 16'h1000, 16'h0000}, {16'h0000, 16'h1000, 16'h0000},
                            {16'h0000, 16'h1000, 16'h0000});
            else
                set_weights(rand_weights(), rand_weights(), rand_weights());
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            write_reg(REG_IMAGE_WIDTH, WREG_W'(w));
            write_reg(REG_IMAGE_HEIGHT, WREG_W'(h));
            if ($urandom_range(9) == 0)
            begin
                n = $urandom_range(1, w * h);
                for (int i = 0; i < n; i++)
                    send_word(OP_PIXEL, rand_pixel());
                sent += n;
            end
            else
            begin
                stream_frame(w, h, ($urandom_range(3) == 0) ? 10 : 0);
                n = $urandom_range(0, 2);
                for (int i = 0; i < n; i++)
                    send_word(opcode_t'($urandom_range(1)), rand_pixel());
                sent += w * h + w + 1 + n;
            end
            wait_idle();
            frame++;
        end
    endtask

    initial
    begin
        errors = 0;
        idle_pct = 0;
        stall_pct = 0;
        quiet_cycles = 0;
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        pix_if.valid = 1'b0;
        pix_if.opcode = OP_PIXEL;
        pix_if.pixel_red = '0;
        pix_if.pixel_green = '0;
        pix_if.pixel_blue = '0;
        res_if.ready = 1'b0;
        cfg_width = SIZE_RESET;
        cfg_height = SIZE_RESET;
        cfg_weights[0] = WEIGHT_RESET;
        cfg_weights[1] = WMID_RESET;
        cfg_weights[2] = WEIGHT_RESET;
        foreach (upper_row[i])
        begin
            upper_row[i] = '0;
            middle_row[i] = '0;
        end
        foreach (win[i])
            win[i] = '0;
        restart_frame();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_size_extremes();
        test_random_frames();

        wait_idle();
        if (errors == 0 && expected_pixels.size() == 0)
            $display("rgb_convolution_3x3 test passed");
        else
            $display("rgb_convolution_3x3 test failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/rgbc_pkg.sv
rtl/core/rgbc_if.sv
rtl/core/rgbc_ctrl.sv
rtl/core/rgbc_line.sv
rtl/core/rgbc_mac.sv
rtl/core/rgb_convolution_3x3.sv
rtl/core/rgbc_checker.sv
verif/rgb_convolution_3x3_tb.sv
